### hw/rtl/wrp_pkg.sv
// Shared constants, codes and helper functions for the weighted residual projection block.
package wrp_pkg;

  // Field and accumulator widths
  localparam int unsigned ValW    = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned DimW    = 7;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  // Default number of vector components held
  localparam int unsigned MaxDimsDef = 8;

  // Register reset values
  localparam logic [ValW-1:0] InvRhoRst     = 32'h0001_0000;
  localparam logic [DimW-1:0] ActiveDimsRst = 7'd8;

  // Item opcodes
  localparam logic [OpW-1:0] OpAcc = 2'd0;
  localparam logic [OpW-1:0] OpMat = 2'd1;
  localparam logic [OpW-1:0] OpFin = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgInvRho     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgActiveDims = 1'b1;

  // Address width of a store of the given depth (at least one bit)
  function automatic int unsigned addr_w(input int unsigned depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Clamp a 64-bit signed value to the 32-bit signed range
  function automatic logic signed [ValW-1:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = 64'shFFFF_FFFF_8000_0000;
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[ValW-1:0];
    end
  endfunction

endpackage

### hw/rtl/wrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [wrp_pkg::addr_w(DEPTH)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [wrp_pkg::addr_w(DEPTH)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/wrp_mul.sv
// Shared 32x32 signed multiplier with a registered 64-bit product.
module wrp_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [wrp_pkg::ValW-1:0]        a_i,
  input  logic signed [wrp_pkg::ValW-1:0]        b_i,
  output logic signed [wrp_pkg::AccW-1:0]        p_o
);

  logic signed [wrp_pkg::AccW-1:0] p_d;
  logic signed [wrp_pkg::AccW-1:0] p_q;

  // Full-precision product
  always_comb begin
    p_d = 64'(a_i) * 64'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### hw/rtl/weighted_residual_project.sv
// Weighted residual projection: sequencer, accumulator stores and output register.
// Accumulate item: two products on the shared multiplier, then read-add-write. Matrix item:
//   store read, one product, read-add-write. Ignored items are accepted and dropped. Finish
//   item: per active component a store read, then an output beat that is loaded once the
//   output is free, so the walk waits while the output stalls.
// Reset (async, active low): inv_rho = 1.0, active_dims = 8, both stores read as zero at once.
module weighted_residual_project #(
  parameter int unsigned MAX_DIMS = wrp_pkg::MaxDimsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wrp_pkg::OpW-1:0]           opcode_i,
  input  logic signed [wrp_pkg::ValW-1:0]   nu_value_i,
  input  logic signed [wrp_pkg::ValW-1:0]   eta_value_i,
  input  logic signed [wrp_pkg::ValW-1:0]   theta_own_i,
  input  logic signed [wrp_pkg::ValW-1:0]   theta_other_i,
  input  logic signed [wrp_pkg::ValW-1:0]   weight_value_i,
  input  logic signed [wrp_pkg::ValW-1:0]   inverse_value_i,
  input  logic [wrp_pkg::IdxW-1:0]          row_index_i,
  input  logic [wrp_pkg::IdxW-1:0]          col_index_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wrp_pkg::ValW-1:0]   xi_value_o,
  output logic [wrp_pkg::IdxW-1:0]          out_index_o,
  output logic                              last_o,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [wrp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wrp_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned AW   = wrp_pkg::addr_w(MAX_DIMS);
  localparam int unsigned VW   = wrp_pkg::ValW;
  localparam int unsigned CW   = wrp_pkg::AccW;
  localparam int unsigned DW   = wrp_pkg::DimW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_MUL1,
    ST_A_TERM,
    ST_A_MUL2,
    ST_A_ACC,
    ST_M_RD,
    ST_M_MUL,
    ST_M_ACC,
    ST_F_RD,
    ST_F_OUT
  } state_e;

  state_e state_q, state_d;

  // Control and output registers
  logic [VW-1:0]         inv_rho_q, inv_rho_d;
  logic [DW-1:0]         dims_q, dims_d;
  logic [MAX_DIMS-1:0]   ws_valid_q, ws_valid_d;
  logic [MAX_DIMS-1:0]   os_valid_q, os_valid_d;
  logic [AW-1:0]         k_q, k_d;
  logic signed [VW-1:0]  term_q, term_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [VW-1:0]  xi_q, xi_d;
  logic [wrp_pkg::IdxW-1:0] idx_q, idx_d;
  logic                  last_q, last_d;

  // Captured item fields
  logic signed [VW-1:0]  nu_q, eta_q, own_q, other_q, weight_q, inverse_q;
  logic [wrp_pkg::IdxW-1:0] row_q, col_q;

  logic                  in_accept;
  logic [DW-1:0]         d_eff;
  logic                  col_ok, row_ok;
  logic                  out_free;
  logic                  fin_last;
  logic                  fin_load;

  // Multiplier interface
  logic                  mul_en;
  logic signed [VW-1:0]  mul_a, mul_b;
  logic signed [CW-1:0]  mul_p;
  logic signed [CW-1:0]  p_shr;
  logic signed [CW-1:0]  term_sum;

  // Store interfaces
  logic                  ws_we, os_we;
  logic [AW-1:0]         ws_raddr, os_raddr, waddr;
  logic [CW-1:0]         ws_rdata, os_rdata;
  logic [CW-1:0]         ws_rd_m, os_rd_m;
  logic [CW-1:0]         ws_wdata, os_wdata;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Effective dimension count, clamped to 1..MAX_DIMS
  always_comb begin
    if (dims_q == '0) begin
      d_eff = DW'(1);
    end else if (dims_q > DW'(MAX_DIMS)) begin
      d_eff = DW'(MAX_DIMS);
    end else begin
      d_eff = dims_q;
    end
  end

  assign col_ok = ({1'b0, col_index_i} < d_eff);
  assign row_ok = ({1'b0, row_index_i} < d_eff);

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      nu_q      <= nu_value_i;
      eta_q     <= eta_value_i;
      own_q     <= theta_own_i;
      other_q   <= theta_other_i;
      weight_q  <= weight_value_i;
      inverse_q <= inverse_value_i;
      row_q     <= row_index_i;
      col_q     <= col_index_i;
    end
  end

  // Store addressing; unwritten entries read as zero
  assign ws_raddr = (state_q == ST_M_RD || state_q == ST_M_MUL) ? row_q[AW-1:0]
                                                               : col_q[AW-1:0];
  assign os_raddr = (state_q == ST_F_RD || state_q == ST_F_OUT) ? k_q : col_q[AW-1:0];
  assign waddr    = col_q[AW-1:0];
  assign ws_rd_m  = ws_valid_q[ws_raddr] ? ws_rdata : '0;
  assign os_rd_m  = os_valid_q[os_raddr] ? os_rdata : '0;

  // Shifted product and residual term
  assign p_shr    = mul_p >>> 16;
  assign term_sum = p_shr + CW'(eta_q) - CW'(own_q) + CW'(other_q);
  assign ws_wdata = ws_rd_m + CW'(p_shr);
  assign os_wdata = os_rd_m + CW'(p_shr);

  // Multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_A_MUL1: begin
        mul_en = 1'b1;
        mul_a  = inv_rho_q;
        mul_b  = nu_q;
      end
      ST_A_MUL2: begin
        mul_en = 1'b1;
        mul_a  = term_q;
        mul_b  = weight_q;
      end
      ST_M_MUL: begin
        mul_en = 1'b1;
        mul_a  = wrp_pkg::sat32($signed(ws_rd_m));
        mul_b  = inverse_q;
      end
      default: begin
      end
    endcase
  end

  assign ws_we    = (state_q == ST_A_ACC);
  assign os_we    = (state_q == ST_M_ACC);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_last = (DW'(k_q) + DW'(1)) == d_eff;
  assign fin_load = (state_q == ST_F_OUT) && out_free;

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    inv_rho_d   = inv_rho_q;
    dims_d      = dims_q;
    ws_valid_d  = ws_valid_q;
    os_valid_d  = os_valid_q;
    k_d         = k_q;
    term_d      = term_q;
    out_valid_d = out_valid_q;
    xi_d        = xi_q;
    idx_d       = idx_q;
    last_d      = last_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        wrp_pkg::CfgInvRho:     inv_rho_d = cfg_data_i[VW-1:0];
        wrp_pkg::CfgActiveDims: dims_d    = cfg_data_i[DW-1:0];
        default: begin
        end
      endcase
    end

    // Output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            wrp_pkg::OpAcc: if (col_ok) state_d = ST_A_MUL1;
            wrp_pkg::OpMat: if (col_ok && row_ok) state_d = ST_M_RD;
            wrp_pkg::OpFin: begin
              k_d     = '0;
              state_d = ST_F_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_A_MUL1: state_d = ST_A_TERM;
      ST_A_TERM: begin
        term_d  = wrp_pkg::sat32(term_sum);
        state_d = ST_A_MUL2;
      end
      ST_A_MUL2: state_d = ST_A_ACC;
      ST_A_ACC: begin
        ws_valid_d[waddr] = 1'b1;
        state_d = ST_IDLE;
      end
      ST_M_RD:  state_d = ST_M_MUL;
      ST_M_MUL: state_d = ST_M_ACC;
      ST_M_ACC: begin
        os_valid_d[waddr] = 1'b1;
        state_d = ST_IDLE;
      end
      ST_F_RD:  state_d = ST_F_OUT;
      ST_F_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          xi_d        = wrp_pkg::sat32($signed(os_rd_m));
          idx_d       = wrp_pkg::IdxW'(k_q);
          last_d      = fin_last;
          if (fin_last) begin
            ws_valid_d = '0;
            os_valid_d = '0;
            state_d    = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_F_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inv_rho_q   <= wrp_pkg::InvRhoRst;
      dims_q      <= wrp_pkg::ActiveDimsRst;
      ws_valid_q  <= '0;
      os_valid_q  <= '0;
      k_q         <= '0;
      term_q      <= '0;
      out_valid_q <= 1'b0;
      xi_q        <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      inv_rho_q   <= inv_rho_d;
      dims_q      <= dims_d;
      ws_valid_q  <= ws_valid_d;
      os_valid_q  <= os_valid_d;
      k_q         <= k_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
      xi_q        <= xi_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign xi_value_o  = xi_q;
  assign out_index_o = idx_q;
  assign last_o      = last_q;

  // Shared multiplier
  wrp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Weighted sums store
  wrp_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_DIMS)
  ) u_ws_ram (
    .clk_i   (clk_i),
    .we_i    (ws_we),
    .waddr_i (waddr),
    .wdata_i (ws_wdata),
    .raddr_i (ws_raddr),
    .rdata_o (ws_rdata)
  );

  // Output sums store
  wrp_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_DIMS)
  ) u_os_ram (
    .clk_i   (clk_i),
    .we_i    (os_we),
    .waddr_i (waddr),
    .wdata_i (os_wdata),
    .raddr_i (os_raddr),
    .rdata_o (os_rdata)
  );

  // Checks
  a_out_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_F_OUT))
    else $error("output beat raised outside the finish walk");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && fin_last) |=> (ws_valid_q == '0 && os_valid_q == '0))
    else $error("stores not cleared after the last beat");

  a_out_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_index_o} < d_eff))
    else $error("output index beyond the active components");

  a_walk_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_RD) |-> (DW'(k_q) < d_eff))
    else $error("finish walk index out of range");

endmodule

### tb/tb_weighted_residual_project.sv
// Self-checking testbench for the weighted residual projection block.
`timescale 1ns / 100ps

module tb_weighted_residual_project;
  import wrp_pkg::*;

  localparam int unsigned MaxDims     = MaxDimsDef;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned SettleTicks = 16;
  localparam int unsigned PhaseItems  = 15;
  localparam int unsigned NumPhases   = 6;

  // opcode that the block has no use for
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [ValW-1:0] nu;
    logic [ValW-1:0] eta;
    logic [ValW-1:0] th_own;
    logic [ValW-1:0] th_other;
    logic [ValW-1:0] weight;
    logic [ValW-1:0] inverse;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } proj_item_t;

  typedef struct packed {
    logic [ValW-1:0] xi;
    logic [IdxW-1:0] index;
    logic            last;
  } xi_beat_t;

  // Column projection model: register copies, both accumulator stores and
  // the queue of output beats still owed by the block
  class column_projection;
    int unsigned     n_errors;
    logic [ValW-1:0] rho_recip;
    logic [DimW-1:0] dims_reg;
    longint          wsum [MaxDims];
    longint          osum [MaxDims];
    xi_beat_t        xi_expected [$];

    function new();
      n_errors  = 0;
      rho_recip = InvRhoRst;
      dims_reg  = ActiveDimsRst;
      clear_sums();
    endfunction

    function void clear_sums();
      foreach (wsum[k]) begin
        wsum[k] = 0;
        osum[k] = 0;
      end
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // components in play: zero acts as one, anything above the store depth is capped
    function int unsigned span();
      int unsigned d;
      d = dims_reg;
      if (d < 1) d = 1;
      if (d > MaxDims) d = MaxDims;
      return d;
    endfunction

    function int unsigned pending();
      return xi_expected.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgInvRho) rho_recip = data[ValW-1:0];
      else if (idx == CfgActiveDims) dims_reg = data[DimW-1:0];
    endfunction

    function void take_item(proj_item_t it);
      int unsigned d;
      int unsigned k;
      longint      scaled;
      longint      term;
      longint      prod;
      longint      v;
      xi_beat_t    beat;
      d = span();
      case (it.op)
        OpAcc: begin
          if (it.col < d) begin
            scaled = (longint'($signed(rho_recip)) * longint'($signed(it.nu))) >>> 16;
            term = clamp32(scaled + longint'($signed(it.eta)) - longint'($signed(it.th_own))
                           + longint'($signed(it.th_other)));
            prod = (term * longint'($signed(it.weight))) >>> 16;
            wsum[it.col] += prod;
          end
        end
        OpMat: begin
          if (it.col < d && it.row < d) begin
            prod = (clamp32(wsum[it.row]) * longint'($signed(it.inverse))) >>> 16;
            osum[it.col] += prod;
          end
        end
        OpFin: begin
          for (k = 0; k < d; k++) begin
            v          = clamp32(osum[k]);
            beat.xi    = v[ValW-1:0];
            beat.index = k[IdxW-1:0];
            beat.last  = (k + 1 == d);
            xi_expected.push_back(beat);
          end
          clear_sums();
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [ValW-1:0] xi, logic [IdxW-1:0] idx, logic fin);
      xi_beat_t want;
      if (xi_expected.size() == 0) begin
        $error("output beat with nothing owed: xi_value %0d out_index %0d last %0b",
               $signed(xi), idx, fin);
        n_errors++;
        return;
      end
      want = xi_expected.pop_front();
      if (want.xi !== xi) begin
        $error("xi_value: expected %0d, got %0d", $signed(want.xi), $signed(xi));
        n_errors++;
      end
      if (want.index !== idx) begin
        $error("out_index: expected %0d, got %0d", want.index, idx);
        n_errors++;
      end
      if (want.last !== fin) begin
        $error("last: expected %0b, got %0b", want.last, fin);
        n_errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  proj_item_t          cur_item;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ValW-1:0]     xi_value_o;
  logic [IdxW-1:0]     out_index_o;
  logic                last_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // both sides run without gaps while this is set
  logic                quiet;
  logic                long_hold_req;

  column_projection proj_model = new();

  weighted_residual_project dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (cur_item.op),
    .nu_value_i      (cur_item.nu),
    .eta_value_i     (cur_item.eta),
    .theta_own_i     (cur_item.th_own),
    .theta_other_i   (cur_item.th_other),
    .weight_value_i  (cur_item.weight),
    .inverse_value_i (cur_item.inverse),
    .row_index_i     (cur_item.row),
    .col_index_i     (cur_item.col),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .xi_value_o      (xi_value_o),
    .out_index_o     (out_index_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #800_000;
    $display("tb_weighted_residual_project: done, errors");
    $finish;
  end

  // Beat monitors, both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) proj_model.take_item(cur_item);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      proj_model.check_beat(xi_value_o, out_index_o, last_o);
  end

  // Result sink: a random hold before each beat, one long hold on request
  initial begin : sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 19);
      end
      @(negedge clk_i);
      out_stall_i = (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Q16.16 operand: modest values, plus the extremes and raw words
  function automatic logic [ValW-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0001_0000;
      5, 6:    return $urandom();
      default: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    endcase
  endfunction

  function automatic proj_item_t make_item(logic [OpW-1:0] op, int unsigned row,
                                           int unsigned col);
    proj_item_t it;
    it.op       = op;
    it.nu       = rand_q16();
    it.eta      = rand_q16();
    it.th_own   = rand_q16();
    it.th_other = rand_q16();
    it.weight   = rand_q16();
    it.inverse  = rand_q16();
    it.row      = row[IdxW-1:0];
    it.col      = col[IdxW-1:0];
    return it;
  endfunction

  task automatic send_item(proj_item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_item   = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every owed beat is out and the sequencer has gone idle
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (proj_model.pending() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    proj_model.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One column: accumulate terms, matrix entries, then finish, with some noise mixed in
  task automatic run_column(output int unsigned used);
    int unsigned d;
    int unsigned n_acc;
    int unsigned n_mat;
    int unsigned i;
    proj_item_t  it;
    d     = proj_model.span();
    used  = 0;
    quiet = ($urandom_range(0, 4) == 0);
    n_acc = $urandom_range(1, 2 * d);
    n_mat = $urandom_range(1, 2 * d);
    for (i = 0; i < n_acc + n_mat; i++) begin
      it = make_item((i < n_acc) ? OpAcc : OpMat, $urandom_range(0, d - 1),
                     $urandom_range(0, d - 1));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: it.op  = OpUnused;
          1: it.col = IdxW'($urandom_range(0, 63));
          2: it.row = IdxW'($urandom_range(0, 63));
          default: it.op = OpAcc;
        endcase
      end else begin
        used++;
      end
      send_item(it);
    end
    send_item(make_item(OpFin, $urandom_range(0, 63), $urandom_range(0, 63)));
    used++;
    quiet = 1'b0;
  endtask

  initial begin
    proj_item_t  it;
    int unsigned phase;
    int unsigned used;
    int unsigned total;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cur_item      = make_item(OpAcc, 0, 0);
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgInvRho;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, saturating terms, edge indices, ignored items
    it = make_item(OpAcc, 0, 0);
    it.nu = 32'h7FFF_FFFF; it.eta = 32'h7FFF_FFFF;
    it.th_own = 32'h8000_0000; it.th_other = 32'h7FFF_FFFF; it.weight = 32'h7FFF_FFFF;
    send_item(it);
    it = make_item(OpAcc, 0, 7);
    it.nu = 32'h8000_0000; it.eta = 32'h8000_0000;
    it.th_own = 32'h7FFF_FFFF; it.th_other = 32'h8000_0000; it.weight = 32'h7FFF_FFFF;
    send_item(it);
    it = make_item(OpAcc, 0, 1);
    it.nu = '0; it.eta = '0; it.th_own = '0; it.th_other = '0; it.weight = '0;
    send_item(it);
    send_item(make_item(OpAcc, 0, 8));
    send_item(make_item(OpAcc, 63, 63));
    it = make_item(OpMat, 0, 0);
    it.inverse = 32'h7FFF_FFFF;
    send_item(it);
    it = make_item(OpMat, 7, 7);
    it.inverse = 32'h8000_0000;
    send_item(it);
    it = make_item(OpMat, 0, 7);
    it.inverse = 32'h8000_0000;
    send_item(it);
    send_item(make_item(OpMat, 63, 0));
    send_item(make_item(OpMat, 0, 8));
    send_item(make_item(OpUnused, 0, 0));
    // accumulate after matrix entries, then a matrix entry that sees it
    send_item(make_item(OpAcc, 0, 0));
    it = make_item(OpMat, 0, 1);
    it.inverse = 32'h0001_0000;
    send_item(it);
    send_item(make_item(OpFin, 0, 0));
    // back-to-back finish reads cleared stores
    send_item(make_item(OpFin, 63, 63));

    // zero dimensions acts as one
    drain_block();
    write_reg(CfgActiveDims, 32'd0);
    send_item(make_item(OpAcc, 0, 0));
    send_item(make_item(OpAcc, 0, 1));
    send_item(make_item(OpMat, 0, 0));
    send_item(make_item(OpMat, 1, 0));
    send_item(make_item(OpFin, 0, 0));

    drain_block();
    write_reg(CfgActiveDims, 32'd3);
    write_reg(CfgInvRho, 32'h0000_8000);
    send_item(make_item(OpAcc, 0, 2));
    send_item(make_item(OpMat, 2, 0));
    send_item(make_item(OpAcc, 0, 3));
    send_item(make_item(OpFin, 0, 0));

    // Random phases, each under its own register setting
    total = 0;
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_block();
      case (phase)
        0: begin
          write_reg(CfgInvRho, $urandom());
          write_reg(CfgActiveDims, 32'd8);
        end
        1: begin
          write_reg(CfgInvRho, 32'h7FFF_FFFF);
          write_reg(CfgActiveDims, 32'd1);
        end
        2: begin
          write_reg(CfgInvRho, 32'h8000_0000);
          write_reg(CfgActiveDims, 32'd127);
        end
        3: begin
          write_reg(CfgInvRho, 32'h0000_0000);
          write_reg(CfgActiveDims, 32'd0);
        end
        4: begin
          write_reg(CfgInvRho, 32'hFFFF_FFFF);
          write_reg(CfgActiveDims, ($urandom() & ~32'h7F) | $urandom_range(2, 7));
        end
        default: begin
          write_reg(CfgInvRho, $urandom_range(0, 32'h0003_FFFF));
          write_reg(CfgActiveDims, 32'd64);
        end
      endcase
      // long sink hold while the source keeps offering, so the block backs up
      if (phase == 0) long_hold_req = 1'b1;
      total = 0;
      while (total < PhaseItems) begin
        run_column(used);
        total += used;
      end
    end

    drain_block();
    repeat (32) @(negedge clk_i);
    if (proj_model.pending() != 0) begin
      $error("%0d output beats never arrived", proj_model.pending());
      proj_model.n_errors++;
    end
    if (proj_model.n_errors == 0) begin
      $display("tb_weighted_residual_project: done, clean");
    end else begin
      $display("tb_weighted_residual_project: done, errors");
    end
    $finish;
  end

endmodule
